@@ rtl/core/wavp_pkg.sv @@
// ----------------------------------------------------------------------------
// wavp_pkg
// Shared types and constants for the WAV PCM stream parser.
// ----------------------------------------------------------------------------
package wavp_pkg;

  // RIFF tags as they sit in a little-endian 32-bit shift word
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] PCM_CODE = 16'd1;
  localparam logic [31:0] FMT_BODY = 32'd16;
  localparam logic [7:0]  U8_BIAS  = 8'd128;

  typedef enum logic [9:0] {
    PH_RIFF  = 10'b00_0000_0001,
    PH_RSIZE = 10'b00_0000_0010,
    PH_WAVE  = 10'b00_0000_0100,
    PH_CTAG  = 10'b00_0000_1000,
    PH_CSIZE = 10'b00_0001_0000,
    PH_FMT   = 10'b00_0010_0000,
    PH_SKIP  = 10'b00_0100_0000,
    PH_DATA  = 10'b00_1000_0000,
    PH_UNSUP = 10'b01_0000_0000,
    PH_IDLE  = 10'b10_0000_0000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_UNSUP  = 2'd3
  } kind_e;

  // sample layout of the data chunk
  typedef struct packed {
    logic bits16;
    logic stereo;
  } fmt_t;

endpackage

@@ rtl/core/wavp_convert.sv @@
// ----------------------------------------------------------------------------
// wavp_convert
// Turns one PCM frame (8/16 bit, mono/stereo) into a signed 16-bit mono sample.
// ----------------------------------------------------------------------------
module wavp_convert import wavp_pkg::*; (
  input  logic [31:0]        frame_i,
  input  fmt_t               fmt_i,
  output logic signed [15:0] sample_o
);

  logic signed [16:0] sum16;
  logic signed [16:0] half16;
  logic [8:0]         sum8;
  logic [7:0]         avg8;

  // stereo average truncates toward zero: bump odd negatives before the shift
  assign sum16  = 17'(signed'(frame_i[15:0])) + 17'(signed'(frame_i[31:16]));
  assign half16 = (sum16 + {16'd0, sum16[16]}) >>> 1;

  assign sum8 = {1'b0, frame_i[7:0]} + {1'b0, frame_i[15:8]};
  assign avg8 = fmt_i.stereo ? sum8[8:1] : frame_i[7:0];

  always_comb begin
    if (fmt_i.bits16) begin
      sample_o = fmt_i.stereo ? half16[15:0] : frame_i[15:0];
    end else begin
      // (u8 - 128) * 256
      sample_o = {avg8 ^ U8_BIAS, 8'h00};
    end
  end

endmodule

@@ rtl/core/wav_pcm_stream_parser.sv @@
// ----------------------------------------------------------------------------
// wav_pcm_stream_parser
// Byte-wide RIFF/WAVE parser: checks tags, reads fmt, reports the header and
// converts PCM frames of the data chunk to signed 16-bit mono samples.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata                        tuser   tlast
//  s_axis    in   [7:0] byte_value             -       last_byte
//  m_axis    out  [15:0] sample, [47:16] rate, kind    last_sample
//                 [63:48] channel_count,
//                 [79:64] sample_bits,
//                 [111:80] data_length
//
// One byte is taken every cycle unless the output register stalls. A byte is
// held in the input register, parsed by the phase logic, and its result (if any)
// is written to the output register when the input register advances.
// Reset (async, active low) returns to the RIFF tag phase, empty pipeline.
// A stalled output register holds the input register; the input side keeps
// streaming as long as the output register is free or drains that cycle.
// tlast on the input ends the file; the parser restarts on the next byte.
// ----------------------------------------------------------------------------
module wav_pcm_stream_parser import wavp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [7:0]    s_axis_tdata_i,   // [7:0] byte_value
  input  logic          s_axis_tlast_i,   // last_byte
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [111:0]  m_axis_tdata_o,   // sample, rate, channel_count,
                                          // sample_bits, data_length
  output logic [1:0]    m_axis_tuser_o,   // kind
  output logic          m_axis_tlast_o    // last_sample
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       in_accept;
  logic       advance;

  // parser state
  phase_e      phase_q, phase_d;
  logic [3:0]  field_bytes_q, field_bytes_d;
  logic [31:0] tag_shift_q, tag_shift_d;
  logic [31:0] chunk_length_q, chunk_length_d;
  logic [31:0] skip_count_q, skip_count_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] channels_q, channels_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] bytes_left_q, bytes_left_d;
  logic [23:0] frame_bytes_q, frame_bytes_d;
  logic [1:0]  frame_index_q, frame_index_d;

  // output register
  logic         out_valid_q;
  logic [1:0]   out_kind_q;
  logic [111:0] out_data_q;
  logic         out_last_q;

  // per-byte result
  logic         res_valid;
  kind_e        res_kind;
  logic         res_last;
  logic [15:0]  res_sample;
  logic [31:0]  res_rate;
  logic [15:0]  res_channels;
  logic [15:0]  res_bits;
  logic [31:0]  res_length;

  logic [31:0]        acc;
  logic               fmt_ok;
  fmt_t               fmt;
  logic [2:0]         frame_size;
  logic [31:0]        frame_word;
  logic [31:0]        bytes_left_dec;
  logic signed [15:0] conv_sample;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  // new byte enters the top of the little-endian shift word
  assign acc = {in_byte_q, tag_shift_q[31:8]};

  assign fmt_ok = (bits_q == 16'd8 || bits_q == 16'd16) &&
                  (channels_q == 16'd1 || channels_q == 16'd2);
  assign fmt.bits16 = (bits_q == 16'd16);
  assign fmt.stereo = (channels_q == 16'd2);
  // bytes per frame: 1, 2 or 4 while in the data phase
  assign frame_size = fmt.bits16 ? (fmt.stereo ? 3'd4 : 3'd2)
                                 : (fmt.stereo ? 3'd2 : 3'd1);
  assign frame_word = {8'd0, frame_bytes_q} |
                      ({24'd0, in_byte_q} << {frame_index_q, 3'b000});
  assign bytes_left_dec = bytes_left_q - 32'd1;

  wavp_convert u_convert (
    .frame_i  (frame_word),
    .fmt_i    (fmt),
    .sample_o (conv_sample)
  );

  always_comb begin
    phase_d        = phase_q;
    field_bytes_d  = field_bytes_q;
    tag_shift_d    = tag_shift_q;
    chunk_length_d = chunk_length_q;
    skip_count_d   = skip_count_q;
    rate_d         = rate_q;
    channels_d     = channels_q;
    bits_d         = bits_q;
    bytes_left_d   = bytes_left_q;
    frame_bytes_d  = frame_bytes_q;
    frame_index_d  = frame_index_q;

    res_valid    = 1'b0;
    res_kind     = KIND_SAMPLE;
    res_last     = 1'b0;
    res_sample   = '0;
    res_rate     = '0;
    res_channels = '0;
    res_bits     = '0;
    res_length   = '0;

    unique case (phase_q)
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_CTAG, PH_CSIZE: begin
        tag_shift_d   = acc;
        field_bytes_d = field_bytes_q + 4'd1;
        if (field_bytes_q[1:0] == 2'd3) begin
          // fourth byte of a tag or size word
          field_bytes_d = '0;
          if (phase_q == PH_RIFF) begin
            if (acc != TAG_RIFF) begin
              res_valid = 1'b1;
              res_kind  = KIND_ERROR;
              phase_d   = PH_IDLE;
            end else begin
              phase_d = PH_RSIZE;
            end
          end else if (phase_q == PH_RSIZE) begin
            phase_d = PH_WAVE;
          end else if (phase_q == PH_WAVE) begin
            if (acc != TAG_WAVE) begin
              res_valid = 1'b1;
              res_kind  = KIND_ERROR;
              phase_d   = PH_IDLE;
            end else begin
              phase_d = PH_CTAG;
            end
          end else if (phase_q == PH_CTAG) begin
            chunk_length_d = acc;   // holds the chunk tag until its size arrives
            phase_d        = PH_CSIZE;
          end else if (chunk_length_q == TAG_FMT) begin
            chunk_length_d = acc;
            phase_d        = PH_FMT;
          end else if (chunk_length_q == TAG_DATA) begin
            chunk_length_d = acc;
            bytes_left_d   = acc;
            frame_bytes_d  = '0;
            frame_index_d  = '0;
            res_valid      = 1'b1;
            if (rate_q == 32'd0 || acc == 32'd0) begin
              res_kind = KIND_ERROR;
              phase_d  = PH_IDLE;
            end else begin
              res_kind     = KIND_HEADER;
              res_rate     = rate_q;
              res_channels = channels_q;
              res_bits     = bits_q;
              res_length   = acc;
              phase_d      = fmt_ok ? PH_DATA : PH_UNSUP;
            end
          end else begin
            // unknown chunk: skip its body
            chunk_length_d = acc;
            skip_count_d   = acc;
            phase_d        = (acc != 32'd0) ? PH_SKIP : PH_CTAG;
          end
        end
      end
      PH_FMT: begin
        tag_shift_d   = acc;
        field_bytes_d = field_bytes_q + 4'd1;
        if (field_bytes_q == 4'd1 && acc[31:16] != PCM_CODE) begin
          res_valid     = 1'b1;
          res_kind      = KIND_ERROR;
          phase_d       = PH_IDLE;
          field_bytes_d = '0;
        end else if (field_bytes_q == 4'd3) begin
          channels_d = acc[31:16];
        end else if (field_bytes_q == 4'd7) begin
          rate_d = acc;
        end else if (field_bytes_q == 4'(FMT_BODY - 32'd1)) begin
          bits_d        = acc[31:16];
          field_bytes_d = '0;
          if (chunk_length_q > FMT_BODY) begin
            skip_count_d = chunk_length_q - FMT_BODY;
            phase_d      = PH_SKIP;
          end else begin
            phase_d = PH_CTAG;
          end
        end
      end
      PH_SKIP: begin
        skip_count_d = skip_count_q - 32'd1;
        if (skip_count_q == 32'd1) begin
          phase_d       = PH_CTAG;
          field_bytes_d = '0;
        end
      end
      PH_DATA: begin
        bytes_left_d = bytes_left_dec;
        if ({1'b0, frame_index_q} + 3'd1 < frame_size) begin
          frame_bytes_d = frame_word[23:0];
          frame_index_d = frame_index_q + 2'd1;
        end else begin
          res_valid     = 1'b1;
          res_kind      = KIND_SAMPLE;
          res_sample    = conv_sample;
          res_last      = (bytes_left_dec < {29'd0, frame_size});
          frame_bytes_d = '0;
          frame_index_d = '0;
        end
        if (bytes_left_dec == 32'd0) begin
          phase_d = PH_IDLE;
        end
      end
      PH_UNSUP: begin
        res_valid = 1'b1;
        res_kind  = KIND_UNSUP;
        phase_d   = PH_IDLE;
      end
      PH_IDLE: begin
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    if (in_last_q) begin
      // file ended before the header without a result of its own
      if (!res_valid && phase_d != PH_DATA && phase_d != PH_UNSUP &&
          phase_d != PH_IDLE) begin
        res_valid = 1'b1;
        res_kind  = KIND_ERROR;
      end
      phase_d        = PH_RIFF;
      field_bytes_d  = '0;
      tag_shift_d    = '0;
      chunk_length_d = '0;
      skip_count_d   = '0;
      rate_d         = '0;
      channels_d     = '0;
      bits_d         = '0;
      bytes_left_d   = '0;
      frame_bytes_d  = '0;
      frame_index_d  = '0;
    end
  end

  // control and parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      phase_q        <= PH_RIFF;
      field_bytes_q  <= '0;
      tag_shift_q    <= '0;
      chunk_length_q <= '0;
      skip_count_q   <= '0;
      rate_q         <= '0;
      channels_q     <= '0;
      bits_q         <= '0;
      bytes_left_q   <= '0;
      frame_bytes_q  <= '0;
      frame_index_q  <= '0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q    <= res_valid;
        phase_q        <= phase_d;
        field_bytes_q  <= field_bytes_d;
        tag_shift_q    <= tag_shift_d;
        chunk_length_q <= chunk_length_d;
        skip_count_q   <= skip_count_d;
        rate_q         <= rate_d;
        channels_q     <= channels_d;
        bits_q         <= bits_d;
        bytes_left_q   <= bytes_left_d;
        frame_bytes_q  <= frame_bytes_d;
        frame_index_q  <= frame_index_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (advance) begin
      out_kind_q <= res_kind;
      out_last_q <= res_last;
      out_data_q <= {res_length, res_bits, res_channels, res_rate, res_sample};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

@@ sim/wav_event_checker.sv @@
// ----------------------------------------------------------------------------
// wav_event_checker
// Watches both stream channels of the WAV parser. Predicts the result of each
// accepted byte and compares every result item against the oldest prediction.
// ----------------------------------------------------------------------------
module wav_event_checker
  import wavp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] byte_value
  input  logic         s_axis_tlast_i,   // last_byte
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  input  logic [111:0] m_axis_tdata_i,   // sample, rate, channel_count,
                                         // sample_bits, data_length
  input  logic [1:0]   m_axis_tuser_i,   // kind
  input  logic         m_axis_tlast_i,   // last_sample
  output int           fail_cnt_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    kind_e       kind;
    logic [15:0] sample;
    logic        last;
    logic [31:0] rate;
    logic [15:0] chans;
    logic [15:0] width;
    logic [31:0] dlen;
  } wav_event_t;

  wav_event_t events_due[$];
  int         mism_cnt  = 0;
  int         n_waiting = 0;

  // parser state
  phase_e      stage;
  logic [31:0] hdr_cnt;
  logic [31:0] shift_word;
  logic [31:0] chunk_word;
  logic [31:0] skip_left;
  logic [31:0] rate_q;
  logic [15:0] chans_q;
  logic [15:0] width_q;
  logic [31:0] data_left;
  logic [23:0] frame_acc;
  logic [1:0]  frame_pos;

  assign fail_cnt_o = mism_cnt;
  assign pending_o  = n_waiting;

  function automatic void clear_state();
    stage      = PH_RIFF;
    hdr_cnt    = '0;
    shift_word = '0;
    chunk_word = '0;
    skip_left  = '0;
    rate_q     = '0;
    chans_q    = '0;
    width_q    = '0;
    data_left  = '0;
    frame_acc  = '0;
    frame_pos  = '0;
  endfunction

  // one whole frame -> signed mono sample, stereo averaged toward zero
  function automatic int to_mono(input logic [31:0] w);
    int a;
    int c;
    if (width_q == 16) begin
      a = signed'(w[15:0]);
      if (chans_q == 1) return a;
      c = signed'(w[31:16]);
      return (a + c) / 2;
    end
    a = w[7:0];
    if (chans_q == 1) return (a - int'(U8_BIAS)) * 256;
    c = w[15:8];
    return ((a + c) / 2 - int'(U8_BIAS)) * 256;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic eof);
    wav_event_t  ev;
    logic        got;
    logic [31:0] acc;
    logic [31:0] idx;
    logic [31:0] fsz;
    logic [31:0] w;
    int          s;
    ev.kind   = KIND_SAMPLE;
    ev.sample = '0;
    ev.last   = 1'b0;
    ev.rate   = '0;
    ev.chans  = '0;
    ev.width  = '0;
    ev.dlen   = '0;
    got = 1'b0;
    acc = {b, shift_word[31:8]};
    case (stage)
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_CTAG, PH_CSIZE: begin
        shift_word = acc;
        hdr_cnt++;
        if (hdr_cnt >= 4) begin
          hdr_cnt = '0;
          case (stage)
            PH_RIFF: begin
              if (shift_word != TAG_RIFF) begin
                ev.kind = KIND_ERROR;
                got     = 1'b1;
                stage   = PH_IDLE;
              end else begin
                stage = PH_RSIZE;
              end
            end
            PH_RSIZE: stage = PH_WAVE;
            PH_WAVE: begin
              if (shift_word != TAG_WAVE) begin
                ev.kind = KIND_ERROR;
                got     = 1'b1;
                stage   = PH_IDLE;
              end else begin
                stage = PH_CTAG;
              end
            end
            PH_CTAG: begin
              chunk_word = shift_word;
              stage      = PH_CSIZE;
            end
            default: begin
              // chunk size word; chunk_word still holds the tag
              if (chunk_word == TAG_FMT) begin
                chunk_word = shift_word;
                stage      = PH_FMT;
              end else if (chunk_word == TAG_DATA) begin
                chunk_word = shift_word;
                data_left  = shift_word;
                frame_acc  = '0;
                frame_pos  = '0;
                got        = 1'b1;
                if (rate_q == 0 || chunk_word == 0) begin
                  ev.kind = KIND_ERROR;
                  stage   = PH_IDLE;
                end else begin
                  ev.kind  = KIND_HEADER;
                  ev.rate  = rate_q;
                  ev.chans = chans_q;
                  ev.width = width_q;
                  ev.dlen  = chunk_word;
                  stage = ((width_q == 8 || width_q == 16) && (chans_q == 1 || chans_q == 2))
                          ? PH_DATA : PH_UNSUP;
                end
              end else begin
                chunk_word = shift_word;
                skip_left  = shift_word;
                stage      = (skip_left != 0) ? PH_SKIP : PH_CTAG;
              end
            end
          endcase
        end
      end
      PH_FMT: begin
        shift_word = acc;
        idx = hdr_cnt;
        hdr_cnt++;
        if (idx == 1 && shift_word[31:16] != PCM_CODE) begin
          ev.kind = KIND_ERROR;
          got     = 1'b1;
          stage   = PH_IDLE;
          hdr_cnt = '0;
        end else if (idx == 3) begin
          chans_q = shift_word[31:16];
        end else if (idx == 7) begin
          rate_q = shift_word;
        end else if (idx == FMT_BODY - 1) begin
          width_q = shift_word[31:16];
          hdr_cnt = '0;
          if (chunk_word > FMT_BODY) begin
            skip_left = chunk_word - FMT_BODY;
            stage     = PH_SKIP;
          end else begin
            stage = PH_CTAG;
          end
        end
      end
      PH_SKIP: begin
        skip_left--;
        if (skip_left == 0) begin
          stage   = PH_CTAG;
          hdr_cnt = '0;
        end
      end
      PH_DATA: begin
        fsz = chans_q * (width_q / 8);
        idx = frame_pos;
        data_left--;
        if (idx + 1 < fsz) begin
          frame_acc = frame_acc | (b << (8 * idx));
          frame_pos = 2'(idx + 1);
        end else begin
          w = {8'h00, frame_acc} | (32'(b) << (8 * idx));
          s = to_mono(w);
          ev.sample = s[15:0];
          ev.last   = (data_left < fsz);
          got       = 1'b1;
          frame_acc = '0;
          frame_pos = '0;
        end
        if (data_left == 0) stage = PH_IDLE;
      end
      PH_UNSUP: begin
        ev.kind = KIND_UNSUP;
        got     = 1'b1;
        stage   = PH_IDLE;
      end
      default: ;
    endcase
    if (eof) begin
      // file ended before the header without a result of its own
      if (!got && (stage inside {PH_RIFF, PH_RSIZE, PH_WAVE, PH_CTAG, PH_CSIZE,
                                 PH_FMT, PH_SKIP})) begin
        ev.kind = KIND_ERROR;
        got     = 1'b1;
      end
      clear_state();
    end
    if (got) events_due.push_back(ev);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mism_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    wav_event_t ev;
    if (!rst_ni) begin
      clear_state();
      events_due.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (events_due.size() == 0) begin
          $error("result item with nothing expected: kind %0d", m_axis_tuser_i);
          mism_cnt++;
        end else begin
          ev = events_due.pop_front();
          check_field("kind", ev.kind, m_axis_tuser_i);
          check_field("sample", ev.sample, m_axis_tdata_i[15:0]);
          check_field("last_sample", ev.last, m_axis_tlast_i);
          check_field("rate", ev.rate, m_axis_tdata_i[47:16]);
          check_field("channel_count", ev.chans, m_axis_tdata_i[63:48]);
          check_field("sample_bits", ev.width, m_axis_tdata_i[79:64]);
          check_field("data_length", ev.dlen, m_axis_tdata_i[111:80]);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) parse_byte(s_axis_tdata_i, s_axis_tlast_i);
    end
    n_waiting = events_due.size();
  end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Feeds whole WAV files, directed corner cases first and then random files,
// into the parser one byte per item; both sides stall at random, not in the
// last third. A checker by the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module testbench import wavp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400_000;
  // byte items in the whole run; random files fill up to this count
  localparam int ITEM_TARGET = 800;
  // spare cycles past the input and output registers to catch stray results
  localparam int DRAIN_CYCLES = 20;

  logic         clk_i   = 1'b0;
  logic         rst_ni  = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata  = '0;
  logic         s_tlast  = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;

  int fail_cnt;
  int pending;

  // idle odds, in percent, of the byte sender and the result receiver;
  // the pattern changes by thirds of the run
  int tx_idle_pct = 37;
  int rx_idle_pct = 78;
  int bytes_sent  = 0;
  int cycle_cnt   = 0;

  // bytes of the file under construction
  logic [7:0] wav_bytes[$];

  always #5ns clk_i = ~clk_i;

  wav_pcm_stream_parser i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  wav_event_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .m_axis_tlast_i  (m_tlast),
    .fail_cnt_o      (fail_cnt),
    .pending_o       (pending)
  );

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk_i) m_tready <= ($urandom_range(99) >= rx_idle_pct);

  // ---- file building --------------------------------------------------------
  task automatic put8(input logic [7:0] v);
    wav_bytes.push_back(v);
  endtask

  task automatic put16(input logic [15:0] v);
    put8(v[7:0]);
    put8(v[15:8]);
  endtask

  task automatic put32(input logic [31:0] v);
    put16(v[15:0]);
    put16(v[31:16]);
  endtask

  // chunk header plus n_body random body bytes (n_body may differ from len)
  task automatic put_chunk(input logic [31:0] tag, input logic [31:0] len,
                           input int n_body);
    put32(tag);
    put32(len);
    repeat (n_body) put8(8'($urandom));
  endtask

  task automatic put_riff_head();
    put32(TAG_RIFF);
    put32($urandom);      // RIFF size is not checked
    put32(TAG_WAVE);
  endtask

  // fmt chunk: the 16-byte body is always written, extra bytes only past 16
  task automatic put_fmt(input logic [31:0] len, input logic [15:0] code,
                         input logic [15:0] chans, input logic [31:0] rate,
                         input logic [15:0] bits);
    put32(TAG_FMT);
    put32(len);
    put16(code);
    put16(chans);
    put32(rate);
    put32($urandom);      // byte rate and block align are not used
    put16(16'($urandom));
    put16(bits);
    if (len > FMT_BODY) repeat (len - FMT_BODY) put8(8'($urandom));
  endtask

  task automatic put_pcm_head(input logic [15:0] chans, input logic [15:0] bits,
                              input logic [31:0] rate);
    put_riff_head();
    put_fmt(FMT_BODY, PCM_CODE, chans, rate, bits);
  endtask

  // ---- driving ----------------------------------------------------------------
  // one byte item; valid goes low only for idle cycles, never in the same step
  // in which it is raised again
  task automatic push_byte(input logic [7:0] b, input logic l);
    if (bytes_sent >= 2 * ITEM_TARGET / 3) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end else if (bytes_sent >= ITEM_TARGET / 3) begin
      tx_idle_pct = 78;
      rx_idle_pct = 37;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  // sends the built file with tlast on its final byte, then empties it
  task automatic ship_file();
    int n;
    n = wav_bytes.size();
    for (int i = 0; i < n; i++) push_byte(wav_bytes[i], i == n - 1);
    wav_bytes.delete();
  endtask

  // random file: mostly well formed headers with random content, some noise,
  // corrupted bytes and cut-off files
  task automatic send_random_file();
    int unsigned chans;
    int unsigned bits;
    int unsigned fmt_len;
    int unsigned data_len;
    int unsigned n_data;
    int unsigned fs;
    int unsigned sel;
    logic [31:0] rate;
    sel = $urandom_range(99);
    if (sel < 8) begin
      repeat ($urandom_range(30, 1)) put8(8'($urandom));
    end else begin
      chans = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(2, 1);
      bits  = ($urandom_range(9) == 0) ? $urandom_range(65535)
                                       : ($urandom_range(1) ? 16 : 8);
      rate  = ($urandom_range(19) == 0) ? 32'd0 : $urandom;
      sel   = $urandom_range(9);
      fmt_len = (sel == 0) ? $urandom_range(15) :
                (sel == 1) ? $urandom_range(24, 17) : FMT_BODY;
      put_riff_head();
      if ($urandom_range(4) == 0) begin
        sel = $urandom_range(6);
        put_chunk($urandom, sel, sel);
      end
      if ($urandom_range(29) != 0)
        put_fmt(fmt_len, ($urandom_range(29) == 0) ? 16'($urandom) : PCM_CODE,
                16'(chans), rate, 16'(bits));
      if ($urandom_range(4) == 0) begin
        sel = $urandom_range(6);
        put_chunk($urandom, sel, sel);
      end
      fs = chans * (bits / 8);
      if (fs == 0 || fs > 4) fs = 1;
      data_len = ($urandom_range(19) == 0) ? 0
                 : fs * $urandom_range(8, 1) + (($urandom_range(4) == 0) ? 1 : 0);
      sel = $urandom_range(9);
      n_data = (sel == 0) ? $urandom_range(data_len) :
               (sel == 1) ? data_len + $urandom_range(6, 1) : data_len;
      put_chunk(TAG_DATA, data_len, n_data);
      if ($urandom_range(19) == 0)
        wav_bytes[$urandom_range(wav_bytes.size() - 1)] = 8'($urandom);
      if ($urandom_range(19) == 0) begin
        sel = $urandom_range(wav_bytes.size(), 1);
        while (wav_bytes.size() > sel) void'(wav_bytes.pop_back());
      end
    end
    ship_file();
  endtask

  // ---- stimulus and verdict -------------------------------------------------
  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // 8-bit mono: byte extremes and the bias midpoint
    put_pcm_head(1, 8, 8000);
    put_chunk(TAG_DATA, 4, 0);
    put8(8'h00); put8(8'hFF); put8(8'h80); put8(8'h7F);
    ship_file();

    // 8-bit stereo with odd sums and a partial trailing frame
    put_pcm_head(2, 8, 22050);
    put_chunk(TAG_DATA, 5, 0);
    put8(8'h00); put8(8'hFF); put8(8'hFF); put8(8'hFF); put8(8'h01);
    ship_file();

    // 16-bit mono extremes
    put_pcm_head(1, 16, 44100);
    put_chunk(TAG_DATA, 4, 0);
    put16(16'h8000); put16(16'h7FFF);
    ship_file();

    // 16-bit stereo: extremes, negative odd sum truncated toward zero, partial
    put_pcm_head(2, 16, 48000);
    put_chunk(TAG_DATA, 9, 0);
    put16(16'h8000); put16(16'h8000);
    put16(16'hFFFF); put16(16'hFFFE);
    put8(8'hAA);
    ship_file();

    // bad RIFF tag ending right on the tag, then one with trailing bytes
    put32(32'h5846_4952);
    ship_file();
    put32(32'h0000_0000); put8(8'h11); put8(8'h22);
    ship_file();

    // bad WAVE tag
    put32(TAG_RIFF); put32(36); put32(TAG_WAVE ^ 32'h1); put8(8'h00);
    ship_file();

    // non-PCM format tag
    put_riff_head();
    put_fmt(FMT_BODY, 16'd3, 1, 8000, 8);
    put_chunk(TAG_DATA, 2, 2);
    ship_file();

    // fmt declared shorter than its body
    put_riff_head();
    put_fmt(12, PCM_CODE, 1, 8000, 8);
    put_chunk(TAG_DATA, 2, 2);
    ship_file();

    // repeated fmt, the second with extra bytes to skip
    put_riff_head();
    put_fmt(FMT_BODY, PCM_CODE, 2, 11025, 8);
    put_fmt(18, PCM_CODE, 1, 48000, 16);
    put_chunk(TAG_DATA, 2, 2);
    ship_file();

    // unknown chunks (one empty), then trailing bytes after the data chunk
    put_riff_head();
    put_chunk(32'h5453_494C, 3, 3);
    put_chunk(32'h7463_6166, 0, 0);
    put_fmt(FMT_BODY, PCM_CODE, 1, 8000, 8);
    put_chunk(TAG_DATA, 1, 4);
    ship_file();

    // data without any fmt chunk
    put_riff_head();
    put_chunk(TAG_DATA, 4, 4);
    ship_file();

    // rate of zero
    put_pcm_head(1, 8, 0);
    put_chunk(TAG_DATA, 2, 2);
    ship_file();

    // empty data chunk
    put_pcm_head(1, 16, 8000);
    put_chunk(TAG_DATA, 0, 1);
    ship_file();

    // file ends early inside a chunk header, and a one-byte file
    put_riff_head();
    put32(TAG_FMT); put8(8'h10);
    ship_file();
    put8(8'h52);
    ship_file();

    // unsupported format with data bytes, and one with no data byte at all
    put_pcm_head(2, 24, 96000);
    put_chunk(TAG_DATA, 6, 6);
    ship_file();
    put_pcm_head(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    put_chunk(TAG_DATA, 32'hFFFF_FFFF, 0);
    ship_file();

    // data chunk far longer than the file
    put_pcm_head(1, 16, 32'hFFFF_FFFF);
    put_chunk(TAG_DATA, 32'hFFFF_FFFF, 3);
    ship_file();

    // random files up to the item count
    while (bytes_sent < ITEM_TARGET) send_random_file();
    s_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/wavp_pkg.sv
rtl/core/wavp_convert.sv
rtl/core/wav_pcm_stream_parser.sv
sim/wav_event_checker.sv
sim/testbench.sv
